### hw/rtl/matk_pkg.sv
// Shared types and constants of the mode aggregate tracker.
package matk_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned OUT_CNT_W = 32;

  // Classified item as it travels from the front queue to the table engine.
  typedef struct packed {
    logic                group_start;
    logic                skip;        // null item or zero weight: no table change
    logic [KEY_W-1:0]    key;
    logic [WEIGHT_W-1:0] weight;
  } op_t;

endpackage

### hw/rtl/matk_if.sv
// Valid/ready channel interfaces for input items and result items.
interface matk_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 group_start;
  logic                                 value_is_null;
  logic signed [matk_pkg::KEY_W-1:0]    key_value;
  logic        [matk_pkg::WEIGHT_W-1:0] weight;

  modport source (output valid, group_start, value_is_null, key_value, weight, input ready);
  modport sink   (input valid, group_start, value_is_null, key_value, weight, output ready);
endinterface

interface matk_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [matk_pkg::KEY_W-1:0]     mode_value;
  logic        [matk_pkg::OUT_CNT_W-1:0] mode_count;
  logic                                  mode_valid;
  logic                                  table_full;

  modport source (output valid, mode_value, mode_count, mode_valid, table_full, input ready);
  modport sink   (input valid, mode_value, mode_count, mode_valid, table_full, output ready);
endinterface

### hw/rtl/matk_front.sv
// Front end: accept items, classify them and hold them in a two-entry queue.
module matk_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  matk_in_if.sink         in_i,
  output logic            op_valid_o,
  output matk_pkg::op_t   op_o,
  input  logic            op_ready_i
);

  matk_pkg::op_t q_mem [2];
  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q, rd_ptr_q;
  logic          push, pop;
  matk_pkg::op_t op_new;

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign op_valid_o = (count_q != 2'd0);
  assign pop        = op_valid_o && op_ready_i;
  assign op_o       = q_mem[rd_ptr_q];

  // A null item and a zero weight both leave the table alone.
  always_comb begin
    op_new.group_start = in_i.group_start;
    op_new.skip        = in_i.value_is_null || (in_i.weight == '0);
    op_new.key         = in_i.key_value;
    op_new.weight      = in_i.weight;
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= op_new;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("front queue count out of range");

endmodule

### hw/rtl/matk_back.sv
// Back end: key/count table scan, saturating count update, running best, result register.
module matk_back #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  input  matk_pkg::op_t   op_i,
  output logic            op_ready_o,
  matk_out_if.source      out_o
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned OUT_W  = matk_pkg::OUT_CNT_W;
  localparam int unsigned SUM_W  =
    ((COUNT_BITS > matk_pkg::WEIGHT_W) ? COUNT_BITS : matk_pkg::WEIGHT_W) + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [FILL_W-1:0]     FILL_MAX  = FILL_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [matk_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]      cnt_mem [TABLE_ENTRIES];

  logic [1:0]                 state_q, state_d;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [IDX_W-1:0]           rd_addr;
  logic [matk_pkg::KEY_W-1:0] rd_key_q;
  logic [COUNT_BITS-1:0]      rd_cnt_q;
  matk_pkg::op_t              cur_q, cur_d;
  logic [COUNT_BITS-1:0]      cnt_q, cnt_d;
  logic                       new_q, new_d;
  logic                       drop_q, drop_d;
  logic [matk_pkg::KEY_W-1:0] best_key_q, best_key_d;
  logic [COUNT_BITS-1:0]      best_cnt_q, best_cnt_d;
  logic                       best_vld_q, best_vld_d;
  logic                       mem_we;
  logic                       out_load;
  logic                       take_best;
  logic [COUNT_BITS-1:0]      sat_base;
  logic [COUNT_BITS-1:0]      sat_cnt;
  logic [SUM_W-1:0]           sum;
  logic [matk_pkg::OUT_CNT_W-1:0] rep_cnt;

  logic                           out_vld_q;
  logic [matk_pkg::KEY_W-1:0]     out_key_q;
  logic [matk_pkg::OUT_CNT_W-1:0] out_cnt_q;
  logic                           out_mv_q;
  logic                           out_full_q;

  function automatic logic [COUNT_BITS-1:0] sat_cnt_from_op(
    input logic [matk_pkg::WEIGHT_W-1:0] w
  );
    logic [SUM_W-1:0] wx;
    wx = SUM_W'(w);
    return (wx > SUM_W'(COUNT_MAX)) ? COUNT_MAX : wx[COUNT_BITS-1:0];
  endfunction

  // Saturating add of the item weight to a stored count (zero on a new entry).
  assign sum     = SUM_W'(sat_base) + SUM_W'(cur_q.weight);
  assign sat_cnt = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_BITS-1:0];

  assign take_best = !best_vld_q || (cnt_q > best_cnt_q) ||
                     ((cnt_q == best_cnt_q) && ($signed(cur_q.key) < $signed(best_key_q)));

  assign out_load = (state_q == S_EMIT) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    new_d      = new_q;
    drop_d     = drop_q;
    best_key_d = best_key_q;
    best_cnt_d = best_cnt_q;
    best_vld_d = best_vld_q;
    op_ready_o = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = '0;
    sat_base   = '0;

    unique case (state_q)
      S_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i) begin
          cur_d  = op_i;
          drop_d = 1'b0;
          idx_d  = '0;
          if (op_i.group_start) begin
            fill_d     = '0;
            best_key_d = '0;
            best_cnt_d = '0;
            best_vld_d = 1'b0;
          end
          if (op_i.skip) begin
            state_d = S_EMIT;
          end else if (op_i.group_start || (fill_q == '0)) begin
            // Empty table: allocate entry zero at once.
            new_d   = 1'b1;
            state_d = S_UPD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = idx_q + IDX_W'(1);
        if (rd_key_q == cur_q.key) begin
          sat_base = rd_cnt_q;
          new_d    = 1'b0;
          state_d  = S_UPD;
        end else if (FILL_W'(idx_q) + FILL_W'(1) == fill_q) begin
          if (fill_q == FILL_MAX) begin
            drop_d  = 1'b1;
            state_d = S_EMIT;
          end else begin
            idx_d   = IDX_W'(fill_q);
            new_d   = 1'b1;
            state_d = S_UPD;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
        cnt_d = sat_cnt;
      end
      S_UPD: begin
        mem_we = 1'b1;
        if (new_q) fill_d = fill_q + FILL_W'(1);
        if (take_best) begin
          best_key_d = cur_q.key;
          best_cnt_d = cnt_q;
          best_vld_d = 1'b1;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // A fresh entry starts from zero, so its count is the saturated weight.
    if (state_q == S_IDLE) begin
      sat_base = '0;
      cnt_d    = sat_cnt_from_op(op_i.weight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      best_key_q <= '0;
      best_cnt_q <= '0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      best_key_q <= best_key_d;
      best_cnt_q <= best_cnt_d;
      best_vld_q <= best_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    cnt_q  <= cnt_d;
    new_q  <= new_d;
    drop_q <= drop_d;
    if (out_load) begin
      out_key_q  <= best_key_q;
      out_cnt_q  <= rep_cnt;
      out_mv_q   <= best_vld_q;
      out_full_q <= drop_q;
    end
  end

  // Table memories: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cnt_mem[idx_q] <= cnt_q;
      if (new_q) key_mem[idx_q] <= cur_q.key;
    end
    rd_key_q <= key_mem[rd_addr];
    rd_cnt_q <= cnt_mem[rd_addr];
  end

  if (COUNT_BITS > matk_pkg::OUT_CNT_W) begin : g_cnt_sat
    assign rep_cnt = (|best_cnt_q[COUNT_BITS-1:matk_pkg::OUT_CNT_W]) ? '1 :
                     best_cnt_q[matk_pkg::OUT_CNT_W-1:0];
  end else begin : g_cnt_ext
    assign rep_cnt = OUT_W'(best_cnt_q);
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.mode_value = out_key_q;
  assign out_o.mode_count = out_cnt_q;
  assign out_o.mode_valid = out_mv_q;
  assign out_o.table_full = out_full_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("table fill count beyond capacity");

  a_scan_in_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (FILL_W'(idx_q) < fill_q))
    else $error("scan index outside filled entries");

  a_drop_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && drop_q) |-> (fill_q == FILL_MAX))
    else $error("item dropped while table has a free entry");

  a_null_best_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !best_vld_q |-> ((best_cnt_q == '0) && (best_key_q == '0)))
    else $error("empty best carries nonzero key or count");

endmodule

### hw/rtl/mode_aggregate_tracker_unit.sv
// Top level of the mode aggregate tracker: front queue plus table engine.
//
//   channel  dir  payload                                          accepted when
//   in_i     in   group_start, value_is_null, key_value, weight    valid && ready
//   out_o    out  mode_value, mode_count, mode_valid, table_full   valid && ready
//
// Timing: a null or zero-weight item goes straight to the result register; the
// scan of a counted item is bounded by F, the number of filled entries (at most
// TABLE_ENTRIES), since the key scan reads one table entry per cycle through the
// single read port of the key/count memory. An empty table or a group start skips
// the scan. The two-entry front queue registers each item before the engine takes it.
// Reset clears the fill count, the best and all handshake state; the table
// memories are not cleared, since only filled entries are ever read.
// Stalls: the front keeps taking items while its queue has room, and the
// engine keeps one finished result in an output register until it is taken.
module mode_aggregate_tracker_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  matk_in_if.sink     in_i,
  matk_out_if.source  out_o
);

  logic          op_valid;
  logic          op_ready;
  matk_pkg::op_t op;

  // Accept and classify items; hold them until the engine is free.
  matk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  // Scan the table, update the count and the best, register the result.
  matk_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .out_o      (out_o)
  );

endmodule

### dv/mode_aggregate_tracker_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the mode aggregate tracker: directed items and random key streams against a predictor.
module mode_aggregate_tracker_unit_tb;

  localparam int unsigned KEY_W     = matk_pkg::KEY_W;
  localparam int unsigned WEIGHT_W  = matk_pkg::WEIGHT_W;
  localparam int unsigned OUT_CNT_W = matk_pkg::OUT_CNT_W;

  localparam int unsigned TABLE_ENTRIES   = 64;
  localparam int unsigned COUNT_BITS      = 32;
  localparam int unsigned TARGET_ITEMS    = 650;  // counted items, null/zero weight excluded
  localparam int unsigned QUIET_ITEMS     = 100;  // pending items left when idling stops
  localparam int unsigned PRESSURE_AT     = 250;  // accepted items before the long hold-off
  localparam int unsigned PRESSURE_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES    = 100;  // covers a full-table scan plus the front queue
  localparam int unsigned REPORT_LIMIT    = 10;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0]     W_MAX   = '1;

  typedef struct packed {
    logic                       group_start;
    logic                       value_is_null;
    logic signed [KEY_W-1:0]    key_value;
    logic        [WEIGHT_W-1:0] weight;
  } tally_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]     mode_value;
    logic        [OUT_CNT_W-1:0] mode_count;
    logic                        mode_valid;
    logic                        table_full;
  } mode_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  matk_in_if  in_if ();
  matk_out_if out_if ();

  mode_aggregate_tracker_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: key/count table, fill marks and the running best.
  logic signed [KEY_W-1:0]      slot_key   [TABLE_ENTRIES];
  logic        [COUNT_BITS-1:0] slot_count [TABLE_ENTRIES];
  logic                         slot_used  [TABLE_ENTRIES];
  logic signed [KEY_W-1:0]      best_key;
  logic        [COUNT_BITS-1:0] best_count;
  logic                         best_valid;

  tally_item_t  pending_q[$];   // items waiting to be offered
  mode_report_t mode_due_q[$];  // predicted results, oldest first

  int unsigned counted_items = 0;
  int unsigned items_in      = 0;
  int unsigned results_seen  = 0;
  int unsigned errors        = 0;
  int unsigned still_cycles  = 0;
  bit          in_took       = 1'b0;
  bit          out_took      = 1'b0;

  // Apply one item to the predicted table and return the result it causes.
  function automatic mode_report_t tally_item(tally_item_t it);
    int                  hit;
    int                  free_slot;
    logic [COUNT_BITS:0] sum;
    logic [COUNT_BITS-1:0] cnt;
    mode_report_t        rep;
    hit       = -1;
    free_slot = -1;
    rep       = '0;
    if (it.group_start) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      best_key   = '0;
      best_count = '0;
      best_valid = 1'b0;
    end
    if (!it.value_is_null && it.weight != '0) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && slot_key[i] == it.key_value) hit = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // A new key takes the lowest free entry; with none free it is dropped.
      if (hit < 0 && free_slot >= 0) begin
        hit             = free_slot;
        slot_used[hit]  = 1'b1;
        slot_key[hit]   = it.key_value;
        slot_count[hit] = '0;
      end
      if (hit < 0) begin
        rep.table_full = 1'b1;
      end else begin
        sum = slot_count[hit] + it.weight;
        cnt = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        slot_count[hit] = cnt;
        // Higher count wins; on equal counts the smaller signed key wins.
        if (!best_valid || cnt > best_count ||
            (cnt == best_count && $signed(it.key_value) < $signed(best_key))) begin
          best_key   = it.key_value;
          best_count = cnt;
          best_valid = 1'b1;
        end
      end
    end
    rep.mode_valid = best_valid;
    rep.mode_value = best_valid ? best_key : '0;
    rep.mode_count = best_valid ? best_count : '0;
    return rep;
  endfunction

  task automatic add_item(bit gs, bit nul, logic signed [KEY_W-1:0] key,
                          logic [WEIGHT_W-1:0] w);
    tally_item_t it;
    it.group_start   = gs;
    it.value_is_null = nul;
    it.key_value     = key;
    it.weight        = w;
    pending_q.push_back(it);
    if (!nul && w != '0) counted_items++;
  endtask

  function automatic logic signed [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Mix small keys (for ties and sign order), extremes and full-width keys.
  function automatic logic signed [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return KEY_W'($signed($urandom_range(0, 8)) - 4);
    if (roll < 35) begin
      case ($urandom_range(0, 3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '1;
        default: return '0;
      endcase
    end
    return rand_key();
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 1;
    if (roll < 84) return $urandom_range(2, 20);
    if (roll < 92) return $urandom;
    if (roll < 97) return W_MAX;
    return $urandom_range(32'h7fff_fff0, 32'h8000_0010);
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Offer items at the falling edge; hold the current one until it is taken.
  int unsigned send_gap        = 0;
  int unsigned send_phase_left = 0;
  bit          send_idle_ok    = 1'b0;

  always @(negedge clk_i) begin : drive_items
    tally_item_t nxt;
    if (rst_ni) begin
      if (send_phase_left == 0) begin
        send_phase_left = $urandom_range(30, 120);
        send_idle_ok    = $urandom_range(0, 2) != 0;
      end else begin
        send_phase_left--;
      end
      if (!in_if.valid || in_took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (send_idle_ok && pending_q.size() > QUIET_ITEMS &&
                     $urandom_range(0, 3) == 0) begin
          // Idle burst of random length, this one included.
          send_gap    = $urandom_range(0, 2);
          in_if.valid <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.group_start   <= nxt.group_start;
          in_if.value_is_null <= nxt.value_is_null;
          in_if.key_value     <= nxt.key_value;
          in_if.weight        <= nxt.weight;
        end
      end
    end
  end

  // Drive ready at the falling edge: short stalls, one long hold-off, none at the end.
  int unsigned hold_left       = 0;
  bit          pressure_done   = 1'b0;
  int unsigned recv_phase_left = 0;
  bit          recv_idle_ok    = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_phase_left == 0) begin
        recv_phase_left = $urandom_range(30, 120);
        recv_idle_ok    = $urandom_range(0, 2) != 0;
      end else begin
        recv_phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!pressure_done && items_in >= PRESSURE_AT) begin
        // Long hold-off: let the front queue and output register fill up.
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES - 1;
        out_if.ready  <= 1'b0;
      end else if (recv_idle_ok && pending_q.size() > QUIET_ITEMS &&
                   $urandom_range(0, 3) == 0) begin
        hold_left    = $urandom_range(0, 2);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Sample both channels at the rising edge: check results first, then predict
  // the accepted item, so a result never meets its own expectation too early.
  always @(posedge clk_i) begin : watch_channels
    tally_item_t  it;
    mode_report_t got;
    mode_report_t want;
    if (rst_ni) begin
      in_took  = in_if.valid && in_if.ready;
      out_took = out_if.valid && out_if.ready;
      if (out_took) begin
        got.mode_value = out_if.mode_value;
        got.mode_count = out_if.mode_count;
        got.mode_valid = out_if.mode_valid;
        got.table_full = out_if.table_full;
        if (mode_due_q.size() == 0) begin
          note_failure($sformatf({"result %0d with nothing expected: ",
                                  "value %0d count %0d valid %0b full %0b"},
                                 results_seen, got.mode_value, got.mode_count,
                                 got.mode_valid, got.table_full));
        end else begin
          want = mode_due_q.pop_front();
          if (got.mode_value !== want.mode_value || got.mode_count !== want.mode_count ||
              got.mode_valid !== want.mode_valid || got.table_full !== want.table_full) begin
            note_failure($sformatf(
              {"result %0d: expected value %0d count %0d valid %0b full %0b, ",
               "got value %0d count %0d valid %0b full %0b"},
              results_seen, want.mode_value, want.mode_count, want.mode_valid,
              want.table_full, got.mode_value, got.mode_count, got.mode_valid,
              got.table_full));
          end
        end
        results_seen++;
      end
      if (in_took) begin
        it.group_start   = in_if.group_start;
        it.value_is_null = in_if.value_is_null;
        it.key_value     = in_if.key_value;
        it.weight        = in_if.weight;
        mode_due_q.push_back(tally_item(it));
        items_in++;
      end
      // Watchdog: end the run when neither channel moves for too long.
      if (in_took || out_took) begin
        still_cycles = 0;
      end else begin
        still_cycles++;
        if (still_cycles >= WATCHDOG_LIMIT) begin
          $display("mode_aggregate_tracker_unit_tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin : run_test
    logic signed [KEY_W-1:0] key_pool [70];
    int unsigned pool_n;
    int unsigned len;
    int unsigned roll;
    int unsigned total_items;
    bit          fill;
    bit          first_group;
    bit          gs;

    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.group_start    = 1'b0;
    in_if.value_is_null  = 1'b0;
    in_if.key_value      = '0;
    in_if.weight         = '0;
    out_if.ready         = 1'b0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    best_key   = '0;
    best_count = '0;
    best_valid = 1'b0;

    // Directed: null before any key, zero weight, ties in signed order,
    // saturation, a tie at the saturated count, and alternating bit patterns.
    add_item(1'b0, 1'b1, KEY_MIN, W_MAX);
    add_item(1'b1, 1'b0, '0, '0);
    add_item(1'b0, 1'b0, KEY_MAX, 1);
    add_item(1'b0, 1'b0, KEY_MIN, 1);
    add_item(1'b0, 1'b0, '1, 1);
    add_item(1'b0, 1'b0, KEY_MAX, 1);
    add_item(1'b0, 1'b1, KEY_W'(5), 7);
    add_item(1'b1, 1'b1, KEY_MAX, 1);
    add_item(1'b0, 1'b0, '0, W_MAX);
    add_item(1'b0, 1'b0, '0, 1);
    add_item(1'b0, 1'b0, '1, W_MAX - 1);
    add_item(1'b0, 1'b0, '1, 32'h8000_0000);
    add_item(1'b0, 1'b0, KEY_W'(1), W_MAX);
    add_item(1'b1, 1'b0, {16{4'h5}}, 32'haaaa_aaaa);
    add_item(1'b0, 1'b0, {16{4'ha}}, 32'h5555_5555);
    add_item(1'b0, 1'b0, {16{4'h5}}, 1);
    add_item(1'b1, 1'b0, KEY_W'(7), 3);

    // Random: groups of keys drawn from a pool. Fill groups use at least as many distinct
    // keys as the table holds, so the table fills up and any further new key hits a full table.
    first_group = 1'b1;
    while (counted_items < TARGET_ITEMS) begin
      fill   = first_group || $urandom_range(0, 9) == 0;
      pool_n = fill ? $urandom_range(TABLE_ENTRIES, 70) : $urandom_range(1, 12);
      for (int i = 0; i < pool_n; i++) key_pool[i] = fill ? rand_key() : pick_key();
      len = fill ? pool_n + $urandom_range(4, 16) : $urandom_range(3, 30);
      for (int j = 0; j < len; j++) begin
        if (fill) begin
          gs = j == 0;
          add_item(gs, 1'b0,
                   (j < pool_n) ? key_pool[j] : key_pool[$urandom_range(0, pool_n - 1)],
                   pick_weight());
        end else begin
          gs   = (j == 0) ? $urandom_range(0, 4) != 0 : $urandom_range(0, 49) == 0;
          roll = $urandom_range(0, 99);
          if (roll < 6) begin
            add_item(gs, 1'b1, rand_key(), $urandom);
          end else if (roll < 10) begin
            add_item(gs, 1'b0, key_pool[$urandom_range(0, pool_n - 1)], '0);
          end else begin
            add_item(gs, 1'b0, key_pool[$urandom_range(0, pool_n - 1)], pick_weight());
          end
        end
      end
      first_group = 1'b0;
    end
    total_items = pending_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (items_in < total_items) @(posedge clk_i);
    while (mode_due_q.size() != 0) @(posedge clk_i);
    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("mode_aggregate_tracker_unit_tb: clean");
    end else begin
      $display("mode_aggregate_tracker_unit_tb: errors");
    end
    $finish;
  end

endmodule
